/* src/dmpcp_pkg.sv */
package dmpcp_pkg;

   localparam int unsigned LineBufferChars = 128;
   localparam logic [12:0] MaxX = 13'd8191;

   typedef enum logic [1:0] {
      PM_TEXT = 2'd0,
      PM_ESC  = 2'd1,
      PM_ARGS = 2'd2,
      PM_GFX  = 2'd3
   } pmode_type;

   typedef enum logic [3:0] {
      PC_NONE    = 4'd0,
      PC_MASTER  = 4'd1,
      PC_GFX     = 4'd2,
      PC_GFX9    = 4'd3,
      PC_FINE    = 4'd4,
      PC_COARSE  = 4'd5,
      PC_INTL    = 4'd6,
      PC_RMARGIN = 4'd7,
      PC_LMARGIN = 4'd8,
      PC_SUPSUB  = 4'd9,
      PC_EXPAND  = 4'd10,
      PC_REVFEED = 4'd11,
      PC_PROP    = 4'd12
   } pcmd_type;

   localparam logic [2:0] EV_CHAR    = 3'd0;
   localparam logic [2:0] EV_GFX     = 3'd1;
   localparam logic [2:0] EV_FEED    = 3'd2;
   localparam logic [2:0] EV_FLUSH   = 3'd3;
   localparam logic [2:0] EV_DISCARD = 3'd4;
   localparam logic [2:0] EV_DROP    = 3'd5;

   localparam logic [2:0] CSR_ALF   = 3'd0;
   localparam logic [2:0] CSR_SZ    = 3'd1;
   localparam logic [2:0] CSR_LW    = 3'd2;
   localparam logic [2:0] CSR_PICA  = 3'd3;
   localparam logic [2:0] CSR_ELITE = 3'd4;
   localparam logic [2:0] CSR_COMP  = 3'd5;
   localparam logic [2:0] CSR_CELT  = 3'd6;
   localparam logic [2:0] CSR_DLS   = 3'd7;

   // mode flag bit positions
   localparam int MF_INTL = 0;
   localparam int MF_ITALIC_INTL = 1;
   localparam int MF_EXP_LINE = 2;
   localparam int MF_EXP_ALWAYS = 3;
   localparam int MF_COMPRESSED = 4;
   localparam int MF_ELITE = 5;
   localparam int MF_PROP = 6;
   localparam int MF_EMPH = 7;
   localparam int MF_DSTRIKE = 8;
   localparam int MF_UNDERLINE = 9;
   localparam int MF_ITALIC = 10;
   localparam int MF_SUPER = 11;
   localparam int MF_SUB = 12;

   typedef struct packed {
      logic [2:0]  kind;
      logic [12:0] head_x;
      logic [8:0]  pins;
      logic [7:0]  code;
      logic [7:0]  attrs;
      logic [8:0]  feed;
   } event_type;

   // attributes derived from mode flags
   function automatic logic [7:0] attrs_of(input logic [12:0] mf);
      logic [7:0] a;
      a = 8'h00;
      if (mf[MF_ELITE]) a[0] = 1'b1;
      else if (mf[MF_PROP]) a[2:1] = 2'b11;
      else if (mf[MF_EMPH]) a[2] = 1'b1;
      if (!a[2] && mf[MF_COMPRESSED]) a[3] = 1'b1;
      if (mf[MF_SUPER]) begin
         a[4] = 1'b1; a[6] = 1'b1;
      end else if (mf[MF_SUB]) begin
         a[5] = 1'b1; a[6] = 1'b1;
      end else if (mf[MF_DSTRIKE]) a[6] = 1'b1;
      if (mf[MF_EXP_LINE]) a[7] = 1'b1;
      return a;
   endfunction

   function automatic logic [3:0] gfx_step(input logic [2:0] m);
      logic [3:0] s;
      case (m)
         3'd0: s = 4'd12;
         3'd1: s = 4'd6;
         3'd2: s = 4'd6;
         3'd3: s = 4'd3;
         3'd4: s = 4'd9;
         3'd5: s = 4'd10;
         3'd6: s = 4'd8;
         default: s = 4'd5;
      endcase
      return s;
   endfunction

endpackage

/* src/dot_matrix_printer_command_parser.sv */
// Command parser for a 9-pin dot-matrix printer host byte stream.
// req_: one host byte per item in req_tdata[7:0].
// rsp_: events; rsp_tuser carries event_kind, rsp_tdata packs head_x,
//   pin_pattern, char_code, char_attrs, feed_units from bit 0 up; rsp_tlast
//   marks the last event of a byte. A byte causes zero to three events.
// csr_: register writes (index, data), always ready.
// A byte is decoded and registered into an event queue of three entries; the
// events then leave one per cycle while the receiver is ready. A byte is taken
// while the last event of the previous byte is being taken, and bytes without
// events go back to back. The first event appears the cycle after the byte is
// accepted.
// Reset (synchronous, active high) returns the parser to text mode with all
// settings and registers at their defaults, so line spacing comes back as
// 36 units. When the receiver stalls, the current event holds and
// req_tready stays low until the queue can drain.
module dot_matrix_printer_command_parser
   import dmpcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // head_x, pin_pattern, char_code, char_attrs,
                                    // feed_units, zero pad
   output logic [2:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast,   // last_event
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_data
);

   // configuration
   logic        alf_ff, sz_ff;
   logic [12:0] lw_ff;
   logic [7:0]  pica_ff, elite_ff, comp_ff, celt_ff;

   // parser state
   pmode_type   pm_ff, pm_in;
   logic [7:0]  arg_ff [3];
   logic [7:0]  arg_in [3];
   logic [1:0]  aidx_ff, aidx_in, acnt_ff, acnt_in;
   pcmd_type    pc_ff, pc_in;
   logic [12:0] mf_ff, mf_in;
   logic [7:0]  at_ff, at_in;
   logic [12:0] lm_ff, lm_in, rm_ff, rm_in;
   logic [7:0]  ls_ff, ls_in, andm_ff, andm_in, xorm_ff, xorm_in;
   logic [12:0] hp_ff, hp_in;
   logic [7:0]  bc_ff, bc_in;
   logic [15:0] gr_ff, gr_in;
   logic [3:0]  gs_ff, gs_in;
   logic [2:0]  gf_ff, gf_in;
   logic [8:0]  pp_ff, pp_in;
   logic [7:0]  hb_ff, hb_in;

   // event queue
   event_type   q_ff [3];
   event_type   q_in [3];
   logic [1:0]  qn_ff, qn_in;
   logic [1:0]  qh_ff;

   logic        accept;
   logic        out_fire;

   assign csr_ready = 1'b1;
   assign out_fire = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (qn_ff != 2'd0);
   assign rsp_tlast = (qn_ff == 2'd1);
   assign req_tready = (qn_ff == 2'd0) || (qn_ff == 2'd1 && rsp_tready);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      event_type e;
      e = q_ff[qh_ff];
      rsp_tdata = {1'b0, e.feed, e.attrs, e.code, e.pins, e.head_x};
      rsp_tuser = e.kind;
   end

   // width of a character under given attributes
   function automatic logic [8:0] cw(input logic [7:0] a, input logic [7:0] p,
      input logic [7:0] el, input logic [7:0] c, input logic [7:0] ce);
      logic [7:0] w;
      w = p;
      if (!a[1]) begin
         case ({a[3], a[0]})
            2'b01: w = el;
            2'b10: w = c;
            2'b11: w = ce;
            default: w = p;
         endcase
      end
      return a[7] ? {w, 1'b0} : {1'b0, w};
   endfunction

   // decode one byte
   always_comb begin
      logic [7:0]  ch, c, a0, ch2;
      logic [1:0]  n, ni;
      logic [8:0]  w;
      logic [13:0] sum;
      logic signed [14:0] rl;
      logic        bv, bval;
      logic [1:0]  bsel;
      logic [16:0] m;
      logic [15:0] gn;
      logic [17:0] mchk;
      logic [12:0] oth;
      logic        do_run, placechar;
      pcmd_type    cmd;
      logic [6:0]  gmode;
      logic [8:0]  pins;
      logic [13:0] nx;
      event_type   ev [3];

      ch = req_tdata;
      n = 2'd0;
      for (int i = 0; i < 3; i++) ev[i] = '0;
      pm_in = pm_ff; arg_in = arg_ff; aidx_in = aidx_ff; acnt_in = acnt_ff;
      pc_in = pc_ff; mf_in = mf_ff; at_in = at_ff; lm_in = lm_ff; rm_in = rm_ff;
      ls_in = ls_ff; andm_in = andm_ff; xorm_in = xorm_ff; hp_in = hp_ff;
      bc_in = bc_ff; gr_in = gr_ff; gs_in = gs_ff; gf_in = gf_ff; pp_in = pp_ff;
      hb_in = hb_ff;
      c = '0; a0 = '0; ch2 = '0; w = '0; sum = '0; bv = 1'b0; bval = 1'b0;
      bsel = '0; m = '0; gn = '0; mchk = '0; oth = '0; do_run = 1'b0;
      placechar = 1'b0; cmd = PC_NONE; gmode = '0; pins = '0;
      nx = '0; ni = '0;
      // right limit goes negative when the line width shrinks under the margin
      rl = $signed({2'b00, lw_ff}) - $signed({2'b00, rm_ff});

      case (pm_ff)
         PM_TEXT: begin
            c = mf_ff[MF_ITALIC_INTL] ? ch : {1'b0, ch[6:0]};
            case (c)
               8'h07, 8'h09, 8'h0B, 8'h0C, 8'h13: ;
               8'h08: begin
                  w = cw(at_ff, pica_ff, elite_ff, comp_ff, celt_ff);
                  if (!mf_ff[MF_PROP] && ({1'b0, lm_ff} + {5'd0, w}) <= {1'b0, hp_ff})
                  begin
                     ev[n].kind = EV_FLUSH; n = n + 2'd1;
                     bc_in = '0;
                     hp_in = hp_ff - {4'd0, w};
                  end
               end
               8'h0A, 8'h0D: begin
                  ev[n].kind = EV_FLUSH; n = n + 2'd1;
                  bc_in = '0;
                  hp_in = lm_ff;
                  if (c == 8'h0A || alf_ff) begin
                     ev[n].kind = EV_FEED; ev[n].feed = {1'b0, ls_ff}; n = n + 2'd1;
                     if (mf_ff[MF_EXP_LINE]) begin
                        mf_in[MF_EXP_LINE] = 1'b0;
                        at_in = attrs_of(mf_in);
                     end
                  end
               end
               8'h0E: mf_in[MF_EXP_LINE] = 1'b1;
               8'h0F: begin mf_in[MF_COMPRESSED] = 1'b1; at_in = attrs_of(mf_in); end
               8'h12: begin mf_in[MF_COMPRESSED] = 1'b0; at_in = attrs_of(mf_in); end
               8'h14: mf_in[MF_EXP_LINE] = 1'b0;
               8'h18: begin
                  ev[n].kind = EV_DISCARD; n = n + 2'd1;
                  bc_in = '0; hp_in = lm_ff;
               end
               8'h1B: pm_in = PM_ESC;
               8'h7F: begin
                  if (bc_ff != 8'd0) begin
                     bc_in = bc_ff - 8'd1;
                     ev[n].kind = EV_DROP; n = n + 2'd1;
                  end
               end
               default: placechar = !(c < 8'h20 && !mf_ff[MF_INTL]);
            endcase
            if (placechar && bc_ff < 8'(LineBufferChars)) begin
               ch2 = (ch & andm_ff) ^ xorm_ff;
               if (mf_ff[MF_ITALIC]) ch2[7] = 1'b1;
               if (sz_ff && ch2[6:0] == 7'h30) ch2 = {ch2[7], 7'h7F};
               w = cw(at_ff, pica_ff, elite_ff, comp_ff, celt_ff);
               sum = {1'b0, hp_ff} + {5'd0, w};
               bc_in = bc_ff;
               hp_in = hp_ff;
               if ($signed({1'b0, sum}) >= rl) begin
                  ev[n].kind = EV_FLUSH; n = n + 2'd1;
                  ev[n].kind = EV_FEED; ev[n].feed = {1'b0, ls_ff}; n = n + 2'd1;
                  bc_in = '0;
                  hp_in = lm_ff;
                  if (mf_ff[MF_EXP_LINE]) begin
                     mf_in[MF_EXP_LINE] = 1'b0;
                     at_in = attrs_of(mf_in);
                  end
                  w = cw(at_in, pica_ff, elite_ff, comp_ff, celt_ff);
               end
               ev[n].kind = EV_CHAR; ev[n].head_x = hp_in; ev[n].code = ch2;
               ev[n].attrs = at_in; n = n + 2'd1;
               bc_in = bc_in + 8'd1;
               sum = {1'b0, hp_in} + {5'd0, w};
               hp_in = sum[13] ? MaxX : sum[12:0];
            end
         end
         PM_ESC: begin
            pm_in = PM_TEXT;
            case (ch)
               8'h21: begin cmd = PC_MASTER; acnt_in = 2'd1; end
               8'h23: begin andm_in = 8'hFF; xorm_in = 8'h00; end
               8'h2A: begin cmd = PC_GFX; acnt_in = 2'd3; end
               8'h30: ls_in = 8'd27;
               8'h31: ls_in = 8'd21;
               8'h32: ls_in = 8'd36;
               8'h33: begin cmd = PC_FINE; acnt_in = 2'd1; end
               8'h34: mf_in[MF_ITALIC] = 1'b1;
               8'h35: mf_in[MF_ITALIC] = 1'b0;
               8'h36: mf_in[MF_ITALIC_INTL] = 1'b1;
               8'h37: mf_in[MF_ITALIC_INTL] = 1'b0;
               8'h3D: begin andm_in = 8'h7F; xorm_in = 8'h00; end
               8'h3E: begin andm_in = 8'h7F; xorm_in = 8'h80; end
               8'h41: begin cmd = PC_COARSE; acnt_in = 2'd1; end
               8'h45: begin mf_in[MF_EMPH] = 1'b1; at_in = attrs_of(mf_in); end
               8'h46: begin mf_in[MF_EMPH] = 1'b0; at_in = attrs_of(mf_in); end
               8'h47: begin mf_in[MF_DSTRIKE] = 1'b1; at_in = attrs_of(mf_in); end
               8'h48: begin mf_in[MF_DSTRIKE] = 1'b0; at_in = attrs_of(mf_in); end
               8'h49: begin cmd = PC_INTL; acnt_in = 2'd1; end
               8'h4B, 8'h4C, 8'h59, 8'h5A: begin
                  cmd = PC_GFX; acnt_in = 2'd3;
                  case (ch)
                     8'h4B: arg_in[0] = 8'd0;
                     8'h4C: arg_in[0] = 8'd1;
                     8'h59: arg_in[0] = 8'd2;
                     default: arg_in[0] = 8'd3;
                  endcase
               end
               8'h4D: begin mf_in[MF_ELITE] = 1'b1; at_in = attrs_of(mf_in); end
               8'h50: begin mf_in[MF_ELITE] = 1'b0; at_in = attrs_of(mf_in); end
               8'h51: begin cmd = PC_RMARGIN; acnt_in = 2'd1; end
               8'h53: begin cmd = PC_SUPSUB; acnt_in = 2'd1; end
               8'h54: begin
                  mf_in[MF_SUPER] = 1'b0; mf_in[MF_SUB] = 1'b0;
                  at_in = attrs_of(mf_in);
               end
               8'h57: begin cmd = PC_EXPAND; acnt_in = 2'd1; end
               8'h5E: begin cmd = PC_GFX9; acnt_in = 2'd3; end
               8'h6A: begin cmd = PC_REVFEED; acnt_in = 2'd1; end
               8'h6C: begin cmd = PC_LMARGIN; acnt_in = 2'd1; end
               8'h70: begin cmd = PC_PROP; acnt_in = 2'd1; end
               default: ;
            endcase
            if (cmd != PC_NONE) begin
               pc_in = cmd; pm_in = PM_ARGS;
               aidx_in = (ch == 8'h4B || ch == 8'h4C || ch == 8'h59 || ch == 8'h5A)
                         ? 2'd1 : 2'd0;
            end
         end
         PM_GFX: begin
            if (!gf_ff[0]) begin
               if (gf_ff[1] && !gr_ff[0]) hb_in = ch;
               else begin
                  nx = {1'b0, hp_ff} + {10'd0, gs_ff};
                  if ($signed({1'b0, nx}) > rl) gf_in[0] = 1'b1;
                  else begin
                     pins = gf_ff[1] ? {hb_ff, ch[7]} : {ch, 1'b0};
                     if (gf_ff[2]) pins = pins & ~pp_ff;
                     pp_in = pins;
                     ev[n].kind = EV_GFX; ev[n].head_x = hp_ff; ev[n].pins = pins;
                     n = n + 2'd1;
                     hp_in = nx[13] ? MaxX : nx[12:0];
                  end
               end
            end
            if (gr_ff <= 16'd1) begin gr_in = '0; pm_in = PM_TEXT; end
            else gr_in = gr_ff - 16'd1;
         end
         default: begin
            bsel = (aidx_ff == 2'd0) ? 2'd0 : ((aidx_ff > 2'd2) ? 2'd2 : aidx_ff);
            arg_in[bsel] = ch;
            ni = aidx_ff + 2'd1;
            aidx_in = ni;
            if (ni >= acnt_ff || ni == 2'd0) begin
               pm_in = PM_TEXT; pc_in = PC_NONE; do_run = 1'b1; cmd = pc_ff;
            end
         end
      endcase

      if (do_run) begin
         a0 = arg_in[0];
         bval = 1'b1;
         case (a0[6:0])
            7'h00, 7'h30: bv = 1'b0;
            7'h01, 7'h31: bv = 1'b1;
            default: bval = 1'b0;
         endcase
         case (cmd)
            PC_MASTER: begin
               mf_in[MF_ELITE] = a0[0]; mf_in[MF_COMPRESSED] = a0[2];
               mf_in[MF_EMPH] = a0[3]; mf_in[MF_DSTRIKE] = a0[4];
               mf_in[MF_EXP_ALWAYS] = a0[5]; mf_in[MF_EXP_LINE] = a0[5];
               at_in = attrs_of(mf_in);
            end
            PC_GFX, PC_GFX9: begin
               if (cmd == PC_GFX9 && a0[6:0] >= 7'd4) a0 = 8'h7F;
               arg_in[0] = a0;
               gn = {1'b0, arg_in[2][6:0], arg_in[1]};
               ev[n].kind = EV_FLUSH; n = n + 2'd1;
               bc_in = '0;
               gr_in = gn;
               if (gn != 16'd0) begin
                  gmode = a0[6:0];
                  gf_in = {gf_ff[2], 2'b01};
                  if (gmode < 7'd8) begin
                     gf_in = (gmode == 7'd2 || gmode == 7'd3) ? 3'b100 : 3'b000;
                     gs_in = gfx_step(gmode[2:0]);
                  end
                  pm_in = PM_GFX;
               end
               if (cmd == PC_GFX9) begin
                  gf_in[1] = 1'b1;
                  gr_in = {gr_in[14:0], 1'b0};
               end
            end
            PC_FINE: ls_in = a0;
            PC_COARSE: if (a0 < 8'd86) ls_in = 8'(a0 * 2'd3);
            PC_INTL: if (bval) mf_in[MF_INTL] = bv;
            PC_RMARGIN, PC_LMARGIN: begin
               w = cw(at_ff, pica_ff, elite_ff, comp_ff, celt_ff);
               m = {9'd0, a0} * {8'd0, w};
               oth = (cmd == PC_RMARGIN) ? lm_ff : rm_ff;
               mchk = {1'b0, m} + 18'd144 + {5'd0, oth};
               if (mchk <= {5'd0, lw_ff}) begin
                  if (cmd == PC_RMARGIN) rm_in = m[12:0];
                  else lm_in = m[12:0];
                  ev[n].kind = EV_DISCARD; n = n + 2'd1;
                  bc_in = '0;
                  hp_in = (cmd == PC_LMARGIN) ? m[12:0] : lm_ff;
               end
            end
            PC_SUPSUB: if (bval) begin
               mf_in[MF_SUPER] = !bv; mf_in[MF_SUB] = bv; at_in = attrs_of(mf_in);
            end
            PC_EXPAND: if (bval) begin
               mf_in[MF_EXP_ALWAYS] = bv; mf_in[MF_EXP_LINE] = bv;
               at_in = attrs_of(mf_in);
            end
            PC_REVFEED: begin
               ev[n].kind = EV_FLUSH; n = n + 2'd1;
               bc_in = '0;
               if (a0 != 8'd0) begin
                  ev[n].kind = EV_FEED; ev[n].feed = -{1'b0, a0}; n = n + 2'd1;
               end
            end
            PC_PROP: if (bval) begin mf_in[MF_PROP] = bv; at_in = attrs_of(mf_in); end
            default: ;
         endcase
      end
      q_in = ev;
      qn_in = n;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alf_ff <= 1'b0; sz_ff <= 1'b0; lw_ff <= 13'd5760;
         pica_ff <= 8'd72; elite_ff <= 8'd60; comp_ff <= 8'd42;
         celt_ff <= 8'd36;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALF: alf_ff <= csr_data[0];
            CSR_SZ: sz_ff <= csr_data[0];
            CSR_LW: lw_ff <= csr_data;
            CSR_PICA: pica_ff <= csr_data[7:0];
            CSR_ELITE: elite_ff <= csr_data[7:0];
            CSR_COMP: comp_ff <= csr_data[7:0];
            CSR_CELT: celt_ff <= csr_data[7:0];
            // default line spacing writes are ignored; reset always restores 36 units
            CSR_DLS: ;
            default: ;
         endcase
      end
   end

   // parser state and event queue
   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff <= PM_TEXT; arg_ff <= '{default: 8'd0}; aidx_ff <= '0; acnt_ff <= '0;
         pc_ff <= PC_NONE; mf_ff <= '0; at_ff <= '0; lm_ff <= '0; rm_ff <= '0;
         ls_ff <= 8'd36; andm_ff <= 8'hFF; xorm_ff <= '0; hp_ff <= '0; bc_ff <= '0;
         gr_ff <= '0; gs_ff <= '0; gf_ff <= '0; pp_ff <= '0; hb_ff <= '0;
         qn_ff <= '0; qh_ff <= '0;
      end else if (accept) begin
         pm_ff <= pm_in; arg_ff <= arg_in; aidx_ff <= aidx_in; acnt_ff <= acnt_in;
         pc_ff <= pc_in; mf_ff <= mf_in; at_ff <= at_in; lm_ff <= lm_in;
         rm_ff <= rm_in; ls_ff <= ls_in; andm_ff <= andm_in; xorm_ff <= xorm_in;
         hp_ff <= hp_in; bc_ff <= bc_in; gr_ff <= gr_in; gs_ff <= gs_in;
         gf_ff <= gf_in; pp_ff <= pp_in; hb_ff <= hb_in;
         q_ff <= q_in; qn_ff <= qn_in; qh_ff <= '0;
      end else if (out_fire) begin
         qn_ff <= qn_ff - 2'd1;
         qh_ff <= qh_ff + 2'd1;
      end
   end

   // a byte is only taken once the queue is empty or draining its last event
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      accept |-> (qn_ff == 2'd0 || (qn_ff == 2'd1 && out_fire)))
      else $error("byte accepted with events pending");
   a_qn_max: assert property (@(posedge clock) disable iff (reset)
      qn_ff != 2'd3 || qh_ff == 2'd0)
      else $error("queue head out of range");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(qn_ff) && $stable(qh_ff)))
      else $error("queue moved during stall");

endmodule
